FILE: hdl/video_si_ti_measure_defines.svh
// Assertion helpers for the SI/TI measurement block.
`ifndef VIDEO_SI_TI_MEASURE_DEFINES_SVH
`define VIDEO_SI_TI_MEASURE_DEFINES_SVH

// Property that holds at every clock edge outside reset.
`define VSTM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition in one cycle implies a condition in the next.
`define VSTM_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

FILE: hdl/vstm_pkg.sv
package vstm_pkg;

  localparam int unsigned PIX_W      = 8;
  localparam int unsigned CFG_W      = 13;
  localparam int unsigned HGT_W      = 13;
  localparam int unsigned ROW_W      = 12;
  localparam int unsigned MAX_HEIGHT = 4096;
  localparam int unsigned MIN_SIZE   = 3;

  // Sobel magnitude: 4 fraction bits, at most 15 bits wide
  localparam int unsigned MAG_FRAC = 4;
  localparam int unsigned MAG_W    = 15;
  localparam int unsigned G2_W     = 21;
  localparam int unsigned RAD_W    = 2 * MAG_W;

  // shared square root unit
  localparam int unsigned ROOT_W     = 64;
  localparam int unsigned ROOT_STEPS = ROOT_W / 2;
  localparam int unsigned SQ_CNT_W   = $clog2(ROOT_STEPS + 1);

  localparam int unsigned OUT_W = 20;

  localparam logic [0:0] CFG_FRAME_WIDTH  = 1'b0;
  localparam logic [0:0] CFG_FRAME_HEIGHT = 1'b1;

  localparam logic [CFG_W-1:0] RESET_WIDTH  = 13'd1920;
  localparam logic [CFG_W-1:0] RESET_HEIGHT = 13'd1080;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_GRAD,
    ST_MAG,
    ST_ACC,
    ST_COUNT,
    ST_MUL_NQ,
    ST_MUL_SS,
    ST_MUL_DEN,
    ST_DIV,
    ST_ROOT,
    ST_NEXT,
    ST_OUT
  } state_e;

endpackage

FILE: hdl/video_si_ti_measure.sv
// SI/TI measurement of a luma stream. Each input word carries a pixel of the current frame
// and the pixel at the same place in the previous frame, in raster order; after the last
// pixel of a frame one word carries SI (sample standard deviation of the Sobel magnitude of
// the interior pixels) and TI (sample standard deviation of cur - prev), both with
// FRACTION_BITS fraction bits, plus a flag that TI was measured against a previous frame.
// A pixel in the first two rows or columns is accepted, then used in a read-modify-write of
// the single-port line buffer memory (MAX_WIDTH x 16 bits); any other pixel then also runs
// the 15-step square root of the gradient. The frame end runs the shift-add multiplier,
// the restoring divider and the 32-step root, one bit or one step per cycle, once for SI
// and once more for TI, or only for SI when the frame has no previous frame and TI is
// skipped; it holds while the previous result word still waits on the output.
// The line buffer has no clearing pass and is ready right after reset.
`include "video_si_ti_measure_defines.svh"

module video_si_ti_measure #(
  parameter int unsigned MAX_WIDTH     = 4096,
  parameter int unsigned FRACTION_BITS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_index_i,
  input  logic [12:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // cur_pixel [7:0], prev_pixel [15:8]
  input  logic        s_axis_tuser,   // prev_valid
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // si_value [19:0], ti_value [39:20]
  output logic        m_axis_tuser    // ti_valid
);

  localparam int unsigned PIX_W = vstm_pkg::PIX_W;
  localparam int unsigned MAG_W = vstm_pkg::MAG_W;
  localparam int unsigned CW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned WW    = $clog2(MAX_WIDTH + 1);
  localparam int unsigned HW    = vstm_pkg::HGT_W;
  localparam int unsigned NW    = WW + HW;
  localparam int unsigned SW    = NW + MAG_W;
  localparam int unsigned QW    = NW + 2 * MAG_W;
  localparam int unsigned DSW   = NW + PIX_W + 1;
  localparam int unsigned DQW   = NW + 2 * PIX_W;
  localparam int unsigned PW    = 2 * NW + 2 * MAG_W + 2 * FRACTION_BITS;
  localparam int unsigned DW    = 2 * NW;
  localparam int unsigned CNT_W = $clog2(PW + 1);
  localparam int unsigned RW    = vstm_pkg::ROOT_W;
  localparam int unsigned OW    = vstm_pkg::OUT_W;
  localparam int unsigned G2S_W = vstm_pkg::G2_W + 1;

  vstm_pkg::state_e state_q, state_d;

  logic [vstm_pkg::CFG_W-1:0] fw_q, fw_d, fh_q, fh_d;
  logic [CW-1:0]              col_q, col_d;
  logic [vstm_pkg::ROW_W-1:0] row_q, row_d;
  logic                       fe_q, fe_d;
  logic                       ch_q, ch_d;
  logic                       apv_q, apv_d;
  logic [PIX_W-1:0]           cur_q, cur_d, prv_q, prv_d;
  logic                       pv_q, pv_d;
  logic [PIX_W-1:0]           win_q [3][3];
  logic [PIX_W-1:0]           win_d [3][3];

  logic [SW-1:0]              sobel_sum_q, sobel_sum_d;
  logic [QW-1:0]              sobel_sq_q, sobel_sq_d;
  logic signed [DSW-1:0]      diff_sum_q, diff_sum_d;
  logic [DQW-1:0]             diff_sq_q, diff_sq_d;

  logic [NW-1:0]              n_q, n_d;
  logic [PW-1:0]              mc_q, mc_d, acc_q, acc_d, p_q, p_d;
  logic [SW-1:0]              mp_q, mp_d;
  logic [CNT_W-1:0]           cnt_q, cnt_d;
  logic [DW-1:0]              den_q, den_d, rem_q, rem_d;

  logic [RW-1:0]              sq_x_q, sq_x_d, sq_res_q, sq_res_d, sq_bit_q, sq_bit_d;
  logic [vstm_pkg::SQ_CNT_W-1:0] sq_cnt_q, sq_cnt_d;

  logic [OW-1:0]              si_q, si_d, ti_q, ti_d;
  logic                       tiv_q, tiv_d;
  logic                       m_valid_q, m_valid_d;

  logic [2*PIX_W-1:0]         line_mem [MAX_WIDTH];
  logic [2*PIX_W-1:0]         rd_q;
  logic                       mem_we;

  logic [WW-1:0]              w_eff, w_in;
  logic [HW-1:0]              h_eff, h_in;
  logic                       col_last, row_last, interior;
  logic [9:0]                 gx_p, gx_n, gy_p, gy_n;
  logic signed [10:0]         gx, gy;
  logic signed [G2S_W-1:0]    gsq;
  logic signed [PIX_W:0]      dd;
  logic signed [2*PIX_W:0]    dsq;
  logic [MAG_W-1:0]           mag;
  logic [2*MAG_W-1:0]         mag_sq;
  logic [DSW-1:0]             dabs;
  logic [NW-1:0]              n_calc;
  logic [PW-1:0]              acc_add, s_diff, q_next;
  logic [DW:0]                rem_sh, rem_new;
  logic                       div_ge;
  logic [RW-1:0]              sq_try, v64, r_val;
  logic                       sq_ge;
  logic [OW-1:0]              res_val;
  logic                       out_free;

  // clamp the size registers
  always_comb begin
    if (fw_q < vstm_pkg::CFG_W'(vstm_pkg::MIN_SIZE)) begin
      w_eff = WW'(vstm_pkg::MIN_SIZE);
    end else if (32'(fw_q) > MAX_WIDTH) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(fw_q);
    end
    if (fh_q < vstm_pkg::CFG_W'(vstm_pkg::MIN_SIZE)) begin
      h_eff = HW'(vstm_pkg::MIN_SIZE);
    end else if (32'(fh_q) > vstm_pkg::MAX_HEIGHT) begin
      h_eff = HW'(vstm_pkg::MAX_HEIGHT);
    end else begin
      h_eff = HW'(fh_q);
    end
  end

  assign col_last = (WW'(col_q) + WW'(1)) >= w_eff;
  assign row_last = (HW'(row_q) + HW'(1)) >= h_eff;
  assign interior = (row_q >= vstm_pkg::ROW_W'(2)) && (col_q >= CW'(2));

  // Sobel on the registered window
  assign gx_p = 10'(win_q[0][2]) + (10'(win_q[1][2]) << 1) + 10'(win_q[2][2]);
  assign gx_n = 10'(win_q[0][0]) + (10'(win_q[1][0]) << 1) + 10'(win_q[2][0]);
  assign gy_p = 10'(win_q[0][0]) + (10'(win_q[0][1]) << 1) + 10'(win_q[0][2]);
  assign gy_n = 10'(win_q[2][0]) + (10'(win_q[2][1]) << 1) + 10'(win_q[2][2]);
  assign gx   = $signed({1'b0, gx_p}) - $signed({1'b0, gx_n});
  assign gy   = $signed({1'b0, gy_p}) - $signed({1'b0, gy_n});
  assign gsq  = gx * gx + gy * gy;

  assign dd     = $signed({1'b0, cur_q}) - $signed({1'b0, prv_q});
  assign dsq    = dd * dd;
  assign mag    = sq_res_q[MAG_W-1:0];
  assign mag_sq = mag * mag;
  assign dabs   = diff_sum_q[DSW-1] ? DSW'(-diff_sum_q) : DSW'(diff_sum_q);

  assign w_in   = ch_q ? w_eff : w_eff - WW'(2);
  assign h_in   = ch_q ? h_eff : h_eff - HW'(2);
  assign n_calc = NW'(w_in) * NW'(h_in);

  assign acc_add = mp_q[0] ? acc_q + mc_q : acc_q;
  assign s_diff  = (p_q >= acc_add) ? p_q - acc_add : '0;

  assign rem_sh  = {rem_q, acc_q[PW-1]};
  assign div_ge  = rem_sh >= {1'b0, den_q};
  assign rem_new = div_ge ? rem_sh - {1'b0, den_q} : rem_sh;
  assign q_next  = {acc_q[PW-2:0], div_ge};
  assign v64     = (|q_next[PW-1:RW]) ? '1 : q_next[RW-1:0];

  assign sq_try  = sq_res_q + sq_bit_q;
  assign sq_ge   = sq_x_q >= sq_try;

  assign r_val   = sq_res_q;
  assign res_val = (den_q == '0) ? '0 : ((|r_val[RW-1:OW]) ? '1 : r_val[OW-1:0]);
  assign out_free = !m_valid_q || m_axis_tready;

  always_comb begin
    state_d    = state_q;
    fw_d       = fw_q;
    fh_d       = fh_q;
    col_d      = col_q;
    row_d      = row_q;
    fe_d       = fe_q;
    ch_d       = ch_q;
    apv_d      = apv_q;
    cur_d      = cur_q;
    prv_d      = prv_q;
    pv_d       = pv_q;
    win_d      = win_q;
    sobel_sum_d = sobel_sum_q;
    sobel_sq_d = sobel_sq_q;
    diff_sum_d = diff_sum_q;
    diff_sq_d  = diff_sq_q;
    n_d        = n_q;
    mc_d       = mc_q;
    acc_d      = acc_q;
    p_d        = p_q;
    mp_d       = mp_q;
    cnt_d      = cnt_q;
    den_d      = den_q;
    rem_d      = rem_q;
    sq_x_d     = sq_x_q;
    sq_res_d   = sq_res_q;
    sq_bit_d   = sq_bit_q;
    sq_cnt_d   = sq_cnt_q;
    si_d       = si_q;
    ti_d       = ti_q;
    tiv_d      = tiv_q;
    m_valid_d  = m_valid_q && !m_axis_tready;
    mem_we     = 1'b0;
    s_axis_tready = 1'b0;

    if (cfg_we_i) begin
      case (cfg_index_i)
        vstm_pkg::CFG_FRAME_WIDTH:  fw_d = cfg_data_i;
        vstm_pkg::CFG_FRAME_HEIGHT: fh_d = cfg_data_i;
        default: ;
      endcase
    end

    case (state_q)
      vstm_pkg::ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          cur_d   = s_axis_tdata[PIX_W-1:0];
          prv_d   = s_axis_tdata[2*PIX_W-1:PIX_W];
          pv_d    = s_axis_tuser;
          state_d = vstm_pkg::ST_READ;
        end
      end

      vstm_pkg::ST_READ: begin
        for (int k = 0; k < 3; k++) begin
          win_d[k][0] = win_q[k][1];
          win_d[k][1] = win_q[k][2];
        end
        win_d[0][2] = rd_q[2*PIX_W-1:PIX_W];
        win_d[1][2] = rd_q[PIX_W-1:0];
        win_d[2][2] = cur_q;
        mem_we      = 1'b1;
        diff_sum_d  = diff_sum_q + DSW'(dd);
        diff_sq_d   = diff_sq_q + DQW'(dsq[2*PIX_W-1:0]);
        if (!pv_q) begin
          apv_d = 1'b0;
        end
        fe_d = 1'b0;
        ch_d = 1'b0;
        if (col_last) begin
          col_d = '0;
          if (row_last) begin
            row_d = '0;
            fe_d  = 1'b1;
          end else begin
            row_d = row_q + vstm_pkg::ROW_W'(1);
          end
        end else begin
          col_d = col_q + CW'(1);
        end
        if (interior) begin
          state_d = vstm_pkg::ST_GRAD;
        end else if (col_last && row_last) begin
          state_d = vstm_pkg::ST_COUNT;
        end else begin
          state_d = vstm_pkg::ST_IDLE;
        end
      end

      vstm_pkg::ST_GRAD: begin
        sq_x_d   = RW'(gsq[vstm_pkg::G2_W-1:0]) << (2 * vstm_pkg::MAG_FRAC);
        sq_res_d = '0;
        sq_bit_d = RW'(1) << (vstm_pkg::RAD_W - 2);
        sq_cnt_d = vstm_pkg::SQ_CNT_W'(MAG_W);
        state_d  = vstm_pkg::ST_MAG;
      end

      vstm_pkg::ST_MAG, vstm_pkg::ST_ROOT: begin
        sq_x_d   = sq_ge ? sq_x_q - sq_try : sq_x_q;
        sq_res_d = sq_ge ? (sq_res_q >> 1) + sq_bit_q : sq_res_q >> 1;
        sq_bit_d = sq_bit_q >> 2;
        sq_cnt_d = sq_cnt_q - vstm_pkg::SQ_CNT_W'(1);
        if (sq_cnt_q == vstm_pkg::SQ_CNT_W'(1)) begin
          state_d = (state_q == vstm_pkg::ST_MAG) ? vstm_pkg::ST_ACC : vstm_pkg::ST_NEXT;
        end
      end

      vstm_pkg::ST_ACC: begin
        sobel_sum_d = sobel_sum_q + SW'(mag);
        sobel_sq_d  = sobel_sq_q + QW'(mag_sq);
        state_d     = fe_q ? vstm_pkg::ST_COUNT : vstm_pkg::ST_IDLE;
      end

      // frame end: n * Q
      vstm_pkg::ST_COUNT: begin
        n_d     = n_calc;
        mc_d    = ch_q ? PW'(diff_sq_q) : PW'(sobel_sq_q);
        mp_d    = SW'(n_calc);
        acc_d   = '0;
        cnt_d   = CNT_W'(NW);
        state_d = vstm_pkg::ST_MUL_NQ;
      end

      vstm_pkg::ST_MUL_NQ, vstm_pkg::ST_MUL_SS, vstm_pkg::ST_MUL_DEN: begin
        acc_d = acc_add;
        mc_d  = mc_q << 1;
        mp_d  = mp_q >> 1;
        cnt_d = cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          case (state_q)
            vstm_pkg::ST_MUL_NQ: begin
              p_d     = acc_add;
              mc_d    = ch_q ? PW'(dabs) : PW'(sobel_sum_q);
              mp_d    = ch_q ? SW'(dabs) : sobel_sum_q;
              acc_d   = '0;
              cnt_d   = CNT_W'(SW);
              state_d = vstm_pkg::ST_MUL_SS;
            end
            vstm_pkg::ST_MUL_SS: begin
              // clamp a negative numerator to zero, then scale
              p_d     = s_diff << (2 * FRACTION_BITS);
              mc_d    = PW'(n_q);
              mp_d    = SW'(n_q - NW'(1));
              acc_d   = '0;
              cnt_d   = CNT_W'(NW);
              state_d = vstm_pkg::ST_MUL_DEN;
            end
            default: begin
              den_d   = acc_add[DW-1:0];
              rem_d   = '0;
              acc_d   = p_q;
              cnt_d   = CNT_W'(PW);
              state_d = vstm_pkg::ST_DIV;
            end
          endcase
        end
      end

      vstm_pkg::ST_DIV: begin
        rem_d = rem_new[DW-1:0];
        acc_d = q_next;
        cnt_d = cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          sq_x_d   = ch_q ? v64 : v64 >> (2 * vstm_pkg::MAG_FRAC);
          sq_res_d = '0;
          sq_bit_d = RW'(1) << (RW - 2);
          sq_cnt_d = vstm_pkg::SQ_CNT_W'(vstm_pkg::ROOT_STEPS);
          state_d  = vstm_pkg::ST_ROOT;
        end
      end

      vstm_pkg::ST_NEXT: begin
        // hold while the previous result word still waits
        if (out_free) begin
          if (!ch_q) begin
            si_d = res_val;
            if (apv_q) begin
              ch_d    = 1'b1;
              state_d = vstm_pkg::ST_COUNT;
            end else begin
              ti_d    = '0;
              state_d = vstm_pkg::ST_OUT;
            end
          end else begin
            ti_d    = res_val;
            state_d = vstm_pkg::ST_OUT;
          end
        end
      end

      vstm_pkg::ST_OUT: begin
        // hold until the output register is free
        if (out_free) begin
          m_valid_d   = 1'b1;
          tiv_d       = apv_q;
          sobel_sum_d = '0;
          sobel_sq_d  = '0;
          diff_sum_d  = '0;
          diff_sq_d   = '0;
          apv_d       = 1'b1;
          fe_d        = 1'b0;
          state_d     = vstm_pkg::ST_IDLE;
        end
      end

      default: state_d = vstm_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      line_mem[col_q] <= {rd_q[PIX_W-1:0], cur_q};
    end
    rd_q <= line_mem[col_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= vstm_pkg::ST_IDLE;
      fw_q        <= vstm_pkg::RESET_WIDTH;
      fh_q        <= vstm_pkg::RESET_HEIGHT;
      col_q       <= '0;
      row_q       <= '0;
      fe_q        <= 1'b0;
      ch_q        <= 1'b0;
      apv_q       <= 1'b1;
      cur_q       <= '0;
      prv_q       <= '0;
      pv_q        <= 1'b0;
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          win_q[r][c] <= '0;
        end
      end
      sobel_sum_q <= '0;
      sobel_sq_q  <= '0;
      diff_sum_q  <= '0;
      diff_sq_q   <= '0;
      n_q         <= '0;
      mc_q        <= '0;
      acc_q       <= '0;
      p_q         <= '0;
      mp_q        <= '0;
      cnt_q       <= '0;
      den_q       <= '0;
      rem_q       <= '0;
      sq_x_q      <= '0;
      sq_res_q    <= '0;
      sq_bit_q    <= '0;
      sq_cnt_q    <= '0;
      si_q        <= '0;
      ti_q        <= '0;
      tiv_q       <= 1'b0;
      m_valid_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      fw_q        <= fw_d;
      fh_q        <= fh_d;
      col_q       <= col_d;
      row_q       <= row_d;
      fe_q        <= fe_d;
      ch_q        <= ch_d;
      apv_q       <= apv_d;
      cur_q       <= cur_d;
      prv_q       <= prv_d;
      pv_q        <= pv_d;
      win_q       <= win_d;
      sobel_sum_q <= sobel_sum_d;
      sobel_sq_q  <= sobel_sq_d;
      diff_sum_q  <= diff_sum_d;
      diff_sq_q   <= diff_sq_d;
      n_q         <= n_d;
      mc_q        <= mc_d;
      acc_q       <= acc_d;
      p_q         <= p_d;
      mp_q        <= mp_d;
      cnt_q       <= cnt_d;
      den_q       <= den_d;
      rem_q       <= rem_d;
      sq_x_q      <= sq_x_d;
      sq_res_q    <= sq_res_d;
      sq_bit_q    <= sq_bit_d;
      sq_cnt_q    <= sq_cnt_d;
      si_q        <= si_d;
      ti_q        <= ti_d;
      tiv_q       <= tiv_d;
      m_valid_q   <= m_valid_d;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {ti_q, si_q};
  assign m_axis_tuser  = tiv_q;

  `VSTM_ASSERT_NEXT(a_accept_reads, s_axis_tvalid && s_axis_tready, state_q == vstm_pkg::ST_READ, "accepted word did not start a line buffer read")
  `VSTM_ASSERT(a_result_from_out, $rose(m_valid_q) |-> $past(state_q) == vstm_pkg::ST_OUT, "result word raised outside the output state")
  `VSTM_ASSERT_NEXT(a_frame_cleared, state_q == vstm_pkg::ST_OUT && state_d == vstm_pkg::ST_IDLE, sobel_sum_q == '0 && diff_sum_q == '0 && apv_q, "frame sums not cleared after result")
  `VSTM_ASSERT_NEXT(a_out_hold, m_valid_q && !m_axis_tready, m_valid_q && $stable(m_axis_tdata), "result word changed while waiting")

endmodule

FILE: test/video_si_ti_measure_checker.sv
`timescale 1ns / 100ps

module video_si_ti_measure_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_index_i,
  input  logic [12:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // cur_pixel [7:0], prev_pixel [15:8]
  input  logic        s_axis_tuser,   // prev_valid
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [39:0] m_axis_tdata,   // si_value [19:0], ti_value [39:20]
  input  logic        m_axis_tuser,   // ti_valid
  output int          fail_count_o,
  output int          pending_o
);

  localparam int unsigned LINE_DEPTH = 4096;
  localparam int unsigned FRAC = 8;

  typedef struct packed {
    logic [19:0] si;
    logic [19:0] ti;
    logic        ti_ok;
  } frame_stats_t;

  frame_stats_t stats_q[$];

  logic [7:0] line1_mem [LINE_DEPTH];
  logic [7:0] line2_mem [LINE_DEPTH];
  int          win [3][3];
  int unsigned width_reg, height_reg, col_cnt, row_cnt;
  longint unsigned mag_sum, mag_sq_sum, dsq_sum;
  longint          dsum;
  bit              all_pv;

  initial begin
    for (int i = 0; i < LINE_DEPTH; i++) begin
      line1_mem[i] = '0;
      line2_mem[i] = '0;
    end
  end

  function automatic logic [63:0] root64(logic [63:0] x);
    logic [63:0] res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= res + b) begin
        x = x - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic logic [19:0] deviation(logic [63:0] n, logic [63:0] s, logic [63:0] q,
                                            int sh_num, int sh_back);
    logic [127:0] a, b, p, quo;
    logic [63:0]  den, v, r;
    if (n < 2) return '0;
    a = {64'd0, n} * {64'd0, q};
    b = {64'd0, s} * {64'd0, s};
    p = (b > a) ? 128'd0 : a - b;
    p = p << sh_num;
    den = n * (n - 1);
    quo = p / {64'd0, den};
    v = (quo[127:64] != 0) ? {64{1'b1}} : quo[63:0];
    v = v >> sh_back;
    r = root64(v);
    return (r > 64'd1048575) ? 20'hFFFFF : r[19:0];
  endfunction

  task automatic clear_frame();
    col_cnt = 0;
    row_cnt = 0;
    mag_sum = 0;
    mag_sq_sum = 0;
    dsum = 0;
    dsq_sum = 0;
    all_pv = 1'b1;
  endtask

  task automatic take_pixel(int cur, int prv, bit pv);
    int unsigned w, h, c, col;
    int gx, gy, d;
    longint unsigned g2, mag, n_in, n_all, dabs;
    frame_stats_t st;
    w = width_reg < vstm_pkg::MIN_SIZE ? vstm_pkg::MIN_SIZE :
        (width_reg > LINE_DEPTH ? LINE_DEPTH : width_reg);
    h = height_reg < vstm_pkg::MIN_SIZE ? vstm_pkg::MIN_SIZE :
        (height_reg > vstm_pkg::MAX_HEIGHT ? vstm_pkg::MAX_HEIGHT : height_reg);
    c = col_cnt;
    col = c < LINE_DEPTH ? c : LINE_DEPTH - 1;
    for (int k = 0; k < 3; k++) begin
      win[k][0] = win[k][1];
      win[k][1] = win[k][2];
    end
    win[0][2] = line2_mem[col];
    win[1][2] = line1_mem[col];
    win[2][2] = cur;
    line2_mem[col] = line1_mem[col];
    line1_mem[col] = cur[7:0];
    if (row_cnt >= 2 && c >= 2) begin
      gx = (win[0][2] + 2 * win[1][2] + win[2][2]) - (win[0][0] + 2 * win[1][0] + win[2][0]);
      gy = (win[0][0] + 2 * win[0][1] + win[0][2]) - (win[2][0] + 2 * win[2][1] + win[2][2]);
      g2 = longint'(gx * gx + gy * gy);
      mag = root64(g2 << (2 * vstm_pkg::MAG_FRAC));
      mag_sum += mag;
      mag_sq_sum += mag * mag;
    end
    d = cur - prv;
    dsum += d;
    dsq_sum += longint'(d * d);
    if (!pv) all_pv = 1'b0;
    if (c + 1 >= w) begin
      col_cnt = 0;
      if (row_cnt + 1 >= h) begin
        n_in = longint'(w - 2) * longint'(h - 2);
        n_all = longint'(w) * longint'(h);
        dabs = dsum < 0 ? -dsum : dsum;
        st.si = deviation(n_in, mag_sum, mag_sq_sum, 2 * FRAC, 2 * vstm_pkg::MAG_FRAC);
        st.ti = all_pv ? deviation(n_all, dabs, dsq_sum, 2 * FRAC, 0) : 20'd0;
        st.ti_ok = all_pv;
        stats_q = {stats_q, st};
        clear_frame();
      end else begin
        row_cnt++;
      end
    end else begin
      col_cnt = c + 1;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    frame_stats_t exp_st;
    if (!rst_ni) begin
      fail_count_o = 0;
      stats_q.delete();
      width_reg = vstm_pkg::RESET_WIDTH;
      height_reg = vstm_pkg::RESET_HEIGHT;
      for (int k = 0; k < 3; k++)
        for (int j = 0; j < 3; j++) win[k][j] = 0;
      clear_frame();
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == vstm_pkg::CFG_FRAME_WIDTH) width_reg = cfg_data_i;
        else height_reg = cfg_data_i;
      end
      if (s_axis_tvalid && s_axis_tready)
        take_pixel(s_axis_tdata[7:0], s_axis_tdata[15:8], s_axis_tuser);
      if (m_axis_tvalid && m_axis_tready) begin
        if (stats_q.size() == 0) begin
          $display("%0t: unexpected result si=%0d ti=%0d ti_valid=%0d", $time,
                   m_axis_tdata[19:0], m_axis_tdata[39:20], m_axis_tuser);
          fail_count_o++;
        end else begin
          exp_st = stats_q.pop_front();
          if (m_axis_tdata[19:0] !== exp_st.si) begin
            $display("%0t: si_value expected %0d actual %0d", $time, exp_st.si,
                     m_axis_tdata[19:0]);
            fail_count_o++;
          end
          if (m_axis_tdata[39:20] !== exp_st.ti) begin
            $display("%0t: ti_value expected %0d actual %0d", $time, exp_st.ti,
                     m_axis_tdata[39:20]);
            fail_count_o++;
          end
          if (m_axis_tuser !== exp_st.ti_ok) begin
            $display("%0t: ti_valid expected %0d actual %0d", $time, exp_st.ti_ok,
                     m_axis_tuser);
            fail_count_o++;
          end
        end
      end
    end
    pending_o = stats_q.size();
  end

endmodule

FILE: test/video_si_ti_measure_tb.sv
`timescale 1ns / 100ps

module video_si_ti_measure_tb;

  localparam int CYCLE_LIMIT = 4000000;

  logic        clk_i, rst_ni;
  logic        cfg_we_i;
  logic [0:0]  cfg_index_i;
  logic [12:0] cfg_data_i;
  logic        s_axis_tvalid, s_axis_tready;
  logic [15:0] s_axis_tdata;
  logic        s_axis_tuser;
  logic        m_axis_tvalid, m_axis_tready;
  logic [39:0] m_axis_tdata;
  logic        m_axis_tuser;
  int          fail_count, pending;
  int          cycles;
  bit          quiet;
  int          random_pixels;

  video_si_ti_measure dut (.*);

  video_si_ti_measure_checker checker_i (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // result side: random stall before each word
  initial begin
    int n;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      n = quiet ? 0 : $urandom_range(0, 13);
      if (n > 0) begin
        m_axis_tready <= 1'b0;
        repeat (n) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  task automatic write_reg(logic [0:0] idx, logic [12:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // hold until every result is in and the pipeline is drained
  task automatic drain();
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic send_pixel(logic [7:0] cur, logic [7:0] prv, logic pv);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {prv, cur};
    s_axis_tuser <= pv;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // pix_mode: 0 random, 1 black/white, 2 smooth; pv_mode: 0 all set, 1 none, 2 random
  task automatic run_frame(int w, int h, int pix_mode, int pv_mode);
    logic [7:0] cur, prv;
    logic pv;
    int base;
    base = $urandom_range(0, 255);
    quiet = ($urandom_range(0, 3) == 0);
    for (int r = 0; r < h; r++) begin
      for (int c = 0; c < w; c++) begin
        case (pix_mode)
          0: cur = 8'($urandom_range(0, 255));
          1: cur = $urandom_range(0, 1) ? 8'hFF : 8'h00;
          default: begin
            base = base + $urandom_range(0, 6) - 3;
            base = base < 0 ? 0 : (base > 255 ? 255 : base);
            cur = 8'(base);
          end
        endcase
        case ($urandom_range(0, 3))
          0: prv = 8'($urandom_range(0, 255));
          1: prv = ~cur;
          default: prv = 8'(cur + $urandom_range(0, 8) - 4);
        endcase
        pv = (pv_mode == 0) ? 1'b1 : (pv_mode == 1 ? 1'b0 : ($urandom_range(0, 15) != 0));
        send_pixel(cur, prv, pv);
      end
    end
    s_axis_tvalid <= 1'b0;
    quiet = 1'b0;
  endtask

  task automatic set_size(logic [12:0] w, logic [12:0] h);
    drain();
    write_reg(vstm_pkg::CFG_FRAME_WIDTH, w);
    write_reg(vstm_pkg::CFG_FRAME_HEIGHT, h);
  endtask

  initial begin
    int w, h;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_index_i = vstm_pkg::CFG_FRAME_WIDTH;
    cfg_data_i = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = 1'b0;
    quiet = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // sizes below the minimum clamp to a 3x3 frame with one interior pixel
    set_size(13'd0, 13'd0);
    send_pixel(8'hFF, 8'h00, 1'b1); send_pixel(8'h00, 8'hFF, 1'b1);
    send_pixel(8'hFF, 8'h00, 1'b1); send_pixel(8'h00, 8'hFF, 1'b1);
    send_pixel(8'hFF, 8'hFF, 1'b1); send_pixel(8'h00, 8'h00, 1'b1);
    send_pixel(8'hFF, 8'h00, 1'b1); send_pixel(8'h00, 8'hFF, 1'b1);
    send_pixel(8'hFF, 8'h00, 1'b1);
    s_axis_tvalid <= 1'b0;
    // one pixel without a previous frame clears ti_valid
    set_size(13'd4, 13'd3);
    for (int i = 0; i < 12; i++)
      send_pixel(i[0] ? 8'hFF : 8'h00, 8'h80, i != 5);
    s_axis_tvalid <= 1'b0;

    random_pixels = 0;
    while (random_pixels < 1450) begin
      w = $urandom_range(3, 10);
      h = $urandom_range(3, 8);
      if ($urandom_range(0, 7) == 0) w = $urandom_range(0, 2);
      set_size(13'(w), 13'(h));
      if (w < 3) w = 3;
      for (int f = 0; f < $urandom_range(1, 3); f++) begin
        run_frame(w, h, $urandom_range(0, 2), ($urandom_range(0, 5) == 0) ?
                  $urandom_range(1, 2) : 0);
        random_pixels += w * h;
      end
    end

    set_size(13'd5, 13'd4);
    run_frame(5, 4, 0, 0);

    drain();
    repeat (500) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
